/* src/eac_pkg.sv */
// Shared types and constants for the emergency alarm controller.
// No dependencies; every other file in src imports this package.
package eac_pkg;

	localparam int unsigned TICKS_W    = 16;
	localparam int unsigned TIMEOUT_W  = 24;
	localparam int unsigned ELAPSED_W  = 24;
	localparam int unsigned PHASE_W    = TICKS_W + 1;
	localparam int unsigned SINCE_W    = 16;
	localparam int unsigned TYPE_W     = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 24;
	localparam int unsigned TDATA_W    = 8;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_EVENT = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUZZER_ON  = 2'd0,
		CFG_BUZZER_OFF = 2'd1,
		CFG_TIMEOUT    = 2'd2,
		CFG_COOLDOWN   = 2'd3
	} cfg_idx_t;

	localparam logic [TICKS_W-1:0]   RST_BUZZER_ON  = 16'd500;
	localparam logic [TICKS_W-1:0]   RST_BUZZER_OFF = 16'd300;
	localparam logic [TIMEOUT_W-1:0] RST_TIMEOUT    = 24'd60000;
	localparam logic [TICKS_W-1:0]   RST_COOLDOWN   = 16'd2000;

	localparam logic [SINCE_W-1:0]   SINCE_MAX   = '1;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	typedef struct packed {
		logic [TICKS_W-1:0]   on_ticks;
		logic [TICKS_W-1:0]   off_ticks;
		logic [TIMEOUT_W-1:0] timeout_ticks;
		logic [TICKS_W-1:0]   cooldown_ticks;
	} cfg_t;

	typedef struct packed {
		logic [TYPE_W-1:0] alert_type;
		logic              alert_pulse;
		logic              alarm_active;
		logic              buzzer_level;
	} res_t;

endpackage

/* src/eac_cfg.sv */
// Configuration register file for the emergency alarm controller.
// Depends on eac_pkg for register indexes, reset values and cfg_t.
module eac_cfg
	import eac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_ticks       <= RST_BUZZER_ON;
			cfg_q.off_ticks      <= RST_BUZZER_OFF;
			cfg_q.timeout_ticks  <= RST_TIMEOUT;
			cfg_q.cooldown_ticks <= RST_COOLDOWN;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_BUZZER_ON:  cfg_q.on_ticks       <= cfg_wdata[TICKS_W-1:0];
				CFG_BUZZER_OFF: cfg_q.off_ticks      <= cfg_wdata[TICKS_W-1:0];
				CFG_TIMEOUT:    cfg_q.timeout_ticks  <= cfg_wdata[TIMEOUT_W-1:0];
				CFG_COOLDOWN:   cfg_q.cooldown_ticks <= cfg_wdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/eac_state.sv */
// Alarm state registers and the single-pass update for one tick or event.
// Depends on eac_pkg for widths, cfg_t and res_t.
module eac_state
	import eac_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              kind,
	input  logic [TYPE_W-1:0] event_type,
	input  cfg_t              cfg,
	output res_t              res
);

	logic                 active_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [PHASE_W-1:0]   phase_q;
	logic [SINCE_W-1:0]   since_q;
	logic                 buzzer_q;
	logic [TYPE_W-1:0]    type_q;

	logic                 active_d;
	logic [ELAPSED_W-1:0] elapsed_d;
	logic [PHASE_W-1:0]   phase_d;
	logic [SINCE_W-1:0]   since_d;
	logic                 buzzer_d;
	logic [TYPE_W-1:0]    type_d;
	logic                 pulse;

	logic [SINCE_W-1:0]   since_inc;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic [PHASE_W-1:0]   period;
	logic [PHASE_W-1:0]   phase_inc;
	logic [PHASE_W-1:0]   phase_wrap;
	logic                 timed_out;

	// Stored phase stays below the largest period (131070), so the increment cannot overflow.
	assign since_inc   = (since_q == SINCE_MAX) ? since_q : since_q + 1'b1;
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : elapsed_q + 1'b1;
	assign period      = {1'b0, cfg.on_ticks} + {1'b0, cfg.off_ticks};
	assign phase_inc   = phase_q + 1'b1;
	assign phase_wrap  = (phase_inc >= period) ? '0 : phase_inc;
	assign timed_out   = elapsed_inc >= cfg.timeout_ticks;

	always_comb begin
		active_d  = active_q;
		elapsed_d = elapsed_q;
		phase_d   = phase_q;
		since_d   = since_q;
		buzzer_d  = buzzer_q;
		type_d    = type_q;
		pulse     = 1'b0;
		if (kind == KIND_TICK) begin
			since_d = since_inc;
			if (active_q) begin
				elapsed_d = elapsed_inc;
				phase_d   = phase_wrap;
				if (timed_out) begin
					active_d = 1'b0;
					buzzer_d = 1'b0;
				end else begin
					buzzer_d = {1'b0, phase_wrap} < {2'b0, cfg.on_ticks};
				end
			end
		end else begin
			type_d = event_type;
			if (!active_q) begin
				// Start of an emergency always alerts.
				active_d  = 1'b1;
				elapsed_d = '0;
				phase_d   = '0;
				pulse     = 1'b1;
			end else begin
				pulse = since_q >= cfg.cooldown_ticks;
			end
			if (pulse) begin
				since_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			elapsed_q <= '0;
			phase_q   <= '0;
			since_q   <= SINCE_MAX;
			buzzer_q  <= 1'b0;
			type_q    <= '0;
		end else if (step) begin
			active_q  <= active_d;
			elapsed_q <= elapsed_d;
			phase_q   <= phase_d;
			since_q   <= since_d;
			buzzer_q  <= buzzer_d;
			type_q    <= type_d;
		end
	end

	assign res.buzzer_level = buzzer_d;
	assign res.alarm_active = active_d;
	assign res.alert_pulse  = pulse;
	assign res.alert_type   = type_d;

	a_buzzer_needs_active: assert property (@(posedge clk) disable iff (!arst_n)
		buzzer_q |-> active_q)
		else $error("buzzer sounding while no emergency is active");

	a_start_clears_counters: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(active_q) |-> (elapsed_q == '0) && (phase_q == '0))
		else $error("emergency started without clearing its counters");

	a_pulse_restarts_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pulse) |=> (since_q == '0))
		else $error("alert did not restart the cooldown counter");

	a_tick_never_pulses: assert property (@(posedge clk) disable iff (!arst_n)
		(kind == KIND_TICK) |-> !pulse)
		else $error("alert raised on a tick");

endmodule

/* src/emergency_alarm_controller.sv */
// Emergency alarm controller top level: input stage, output register, handshakes.
// Depends on eac_pkg, eac_cfg and eac_state.
//
// Usage:
//   Slave channel s_*: one beat per item. s_tuser is the kind (0 = 1 ms tick,
//   1 = emergency event); s_tdata[1:0] is the event type, used by events only.
//   Master channel m_*: exactly one result beat per input beat, in order.
//   Configuration: write cfg_wdata to register cfg_addr (0 buzzer on ticks,
//   1 buzzer off ticks, 2 emergency timeout ticks, 3 alert cooldown ticks)
//   at any edge with cfg_we high; write only while no beats are in flight.
// Timing:
//   A beat accepted on s_* lands in the input stage; when the stage advances, the state
//   update runs in one combinational pass into the output register, which drives
//   m_tvalid. One beat per cycle is sustained as long as m_tready stays high: the
//   input stage advances whenever the output register is empty or drains in the
//   same cycle.
// Stall: with m_tready low, the result holds in the output register and one
//   more beat waits in the input stage; s_tready then drops.
// Reset: arst_n clears both stages, the alarm state (idle, buzzer off, cooldown
//   saturated) and restores the default configuration.
module emergency_alarm_controller
	import eac_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [TDATA_W-1:0]    s_tdata,   // [1:0] event_type, rest zero
	input  logic                  s_tuser,   // [0] kind
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_W-1:0]    m_tdata,   // [0] buzzer_level, [1] alarm_active,
	                                         // [2] alert_pulse, [4:3] alert_type
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t              cfg;
	res_t              res;
	logic              valid_s1;
	logic              kind_s1;
	logic [TYPE_W-1:0] type_s1;
	logic              out_valid_q;
	res_t              res_q;
	logic              advance;
	logic              in_take;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign in_take  = s_tvalid && s_tready;

	eac_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	eac_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.kind       (kind_s1),
		.event_type (type_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: no reset, qualified by the valid flags.
	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1 <= s_tuser;
			type_s1 <= s_tdata[TYPE_W-1:0];
		end
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W - TYPE_W - 3){1'b0}}, res_q.alert_type,
		res_q.alert_pulse, res_q.alarm_active, res_q.buzzer_level};

endmodule
